// ----- sv/nlsc_pkg.sv -----
// Shared types and constants for the length-prefix to start-code converter.
// No dependencies; every other file imports this package.
package nlsc_pkg;

    localparam int QUEUE_DEPTH = 5;
    localparam int SIZE_W = 31;
    localparam int LEN_W = 32;
    localparam int HDR_BYTES = 4;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_HELD = 2'd2;

    localparam logic [7:0] START_LAST_BYTE = 8'h01;

    typedef struct packed {
        logic [1:0] kind;
        logic [LEN_W-1:0] word;
        logic unit_end;
    } nlsc_cmd_t;

endpackage

// ----- sv/nlsc_stream_if.sv -----
// Handshake interfaces for the input byte stream and the converted output stream.
// Depends on nlsc_pkg for the field widths.
interface nlsc_in_if
    import nlsc_pkg::*;
();
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic [SIZE_W-1:0] unit_size;

    modport source (output valid, output data_byte, output unit_size, input ready);
    modport sink (input valid, input data_byte, input unit_size, output ready);
endinterface

interface nlsc_out_if;
    logic valid;
    logic ready;
    logic [7:0] out_byte;
    logic unit_end;
    logic run_last;

    modport source (output valid, output out_byte, output unit_end, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input unit_end, input run_last,
                  output ready);
endinterface

// ----- sv/nal_length_prefix_to_start_code.sv -----
// Top level of the length-prefix to start-code converter.
// Depends on nlsc_pkg, the stream interfaces, nlsc_front, nlsc_queue and nlsc_back.
//
//   Channel        Direction  Beat contents
//   unit_stream    in         data_byte, unit_size
//   annexb_stream  out        out_byte, unit_end, run_last
//
// The fourth byte of a parsed header expands into four output beats, one per cycle
// while the output is ready, so one byte per cycle is sustained. Reset clears the
// parse state and the command queue at once. The input is taken whenever the queue
// has room, regardless of the output side; an output stall holds the sequencer and
// reaches the input only once the queue is full.
module nal_length_prefix_to_start_code
    import nlsc_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    nlsc_in_if.sink     unit_stream,
    nlsc_out_if.source  annexb_stream
);

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    nlsc_cmd_t push_cmd, pop_cmd;

    nlsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_stream (unit_stream),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    nlsc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    nlsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .annexb_stream (annexb_stream)
    );

endmodule

// ----- sv/nlsc_front.sv -----
// Front end: tracks the unit, parses length headers and issues output commands.
// Depends on nlsc_pkg and the nlsc_in_if interface.
module nlsc_front
    import nlsc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    nlsc_in_if.sink        unit_stream,
    output logic           push_valid,
    input  logic           push_ready,
    output nlsc_cmd_t      push_cmd
);

    localparam logic [1:0] MODE_EXPECT = 2'd0;
    localparam logic [1:0] MODE_HOLD = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [23:0] held_reg, held_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;

    logic fire;
    logic unit_last;
    logic has_cmd;
    logic [1:0] mode_eff;
    logic [LEN_W-1:0] len;
    logic [SIZE_W-1:0] rem_dec;

    assign unit_stream.ready = push_ready;
    assign fire = unit_stream.valid && push_ready;
    assign len = {held_reg, unit_stream.data_byte};
    assign rem_dec = rem_reg - SIZE_W'(1);

    always_comb
    begin
        size_next = (pos_reg == '0) ? unit_stream.unit_size : size_reg;
        unit_last = ({1'b0, pos_reg} + LEN_W'(1)) >= {1'b0, size_next};
        pos_next = pos_reg;
        mode_next = mode_reg;
        cnt_next = cnt_reg;
        held_next = held_reg;
        rem_next = rem_reg;
        has_cmd = 1'b1;
        push_cmd.kind = CMD_BYTE;
        push_cmd.word = {24'd0, unit_stream.data_byte};
        push_cmd.unit_end = unit_last;

        mode_eff = mode_reg;
        if (mode_reg == MODE_EXPECT)
        begin
            if (({1'b0, pos_reg} + LEN_W'(HDR_BYTES)) < {1'b0, size_next})
            begin
                mode_eff = MODE_HOLD;
                cnt_next = 2'd0;
                held_next = 24'd0;
            end
            else
            begin
                mode_eff = MODE_PASS;
            end
        end
        mode_next = mode_eff;

        unique case (mode_eff)
            MODE_HOLD:
            begin
                if (cnt_reg != 2'd3 || mode_reg == MODE_EXPECT)
                begin
                    has_cmd = 1'b0;
                    held_next = (mode_reg == MODE_EXPECT) ? {16'd0, unit_stream.data_byte}
                                                          : {held_reg[15:0], unit_stream.data_byte};
                    cnt_next = (mode_reg == MODE_EXPECT) ? 2'd1 : cnt_reg + 2'd1;
                end
                else
                begin
                    if (len <= {1'b0, size_next})
                    begin
                        push_cmd.kind = CMD_START;
                        rem_next = len[SIZE_W-1:0];
                        mode_next = (len != '0) ? MODE_PAYLOAD : MODE_EXPECT;
                    end
                    else
                    begin
                        push_cmd.kind = CMD_HELD;
                        push_cmd.word = len;
                        mode_next = MODE_PASS;
                    end
                    cnt_next = 2'd0;
                    held_next = 24'd0;
                end
            end
            MODE_PAYLOAD:
            begin
                if (rem_reg != '0)
                begin
                    rem_next = rem_dec;
                end
                if (rem_reg == '0 || rem_dec == '0)
                begin
                    mode_next = MODE_EXPECT;
                end
            end
            default:
            begin
                mode_next = mode_eff;
            end
        endcase

        if (unit_last)
        begin
            pos_next = '0;
            mode_next = MODE_EXPECT;
            cnt_next = 2'd0;
            held_next = 24'd0;
            rem_next = '0;
        end
        else
        begin
            pos_next = pos_reg + SIZE_W'(1);
        end
    end

    assign push_valid = fire && has_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            size_reg <= '0;
            mode_reg <= MODE_EXPECT;
            cnt_reg <= 2'd0;
            held_reg <= 24'd0;
            rem_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            size_reg <= size_next;
            mode_reg <= mode_next;
            cnt_reg <= cnt_next;
            held_reg <= held_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- sv/nlsc_queue.sv -----
// Short command queue between the front end and the output sequencer.
// Depends on nlsc_pkg for the command type.
module nlsc_queue
    import nlsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  nlsc_cmd_t push_cmd,
    output logic      pop_valid,
    input  logic      pop_ready,
    output nlsc_cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nlsc_cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/nlsc_back.sv -----
// Output sequencer: expands each queued command into one or four output beats.
// Depends on nlsc_pkg and the nlsc_out_if interface.
module nlsc_back
    import nlsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  nlsc_cmd_t pop_cmd,
    nlsc_out_if.source annexb_stream
);

    logic [1:0] idx_reg, idx_next;
    logic last_beat;
    logic fire;

    assign last_beat = (pop_cmd.kind == CMD_BYTE) || (idx_reg == 2'd3);
    assign fire = pop_valid && annexb_stream.ready;

    assign annexb_stream.valid = pop_valid;
    assign annexb_stream.run_last = last_beat;
    assign annexb_stream.unit_end = last_beat && pop_cmd.unit_end;
    assign pop_ready = annexb_stream.ready && last_beat;

    always_comb
    begin
        unique case (pop_cmd.kind)
            CMD_START:
            begin
                annexb_stream.out_byte = (idx_reg == 2'd3) ? START_LAST_BYTE : 8'h00;
            end
            CMD_HELD:
            begin
                case (idx_reg)
                    2'd0: annexb_stream.out_byte = pop_cmd.word[31:24];
                    2'd1: annexb_stream.out_byte = pop_cmd.word[23:16];
                    2'd2: annexb_stream.out_byte = pop_cmd.word[15:8];
                    default: annexb_stream.out_byte = pop_cmd.word[7:0];
                endcase
            end
            default:
            begin
                annexb_stream.out_byte = pop_cmd.word[7:0];
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last_beat ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
